// ----- rtl/core/dsq_pkg.sv -----
// Shared types, codes and the deadline comparison for the deadline sleep queue.
// Used by dsq_cell and deadline_sleep_queue_core; depends on nothing else.
`default_nettype none

package dsq_pkg;

	localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_NSEC  = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD   = 3'd0,
		OP_MARK   = 3'd1,
		OP_STEP   = 3'd2,
		OP_INSERT = 3'd3,
		OP_REMOVE = 3'd4
	} op_t;

	typedef struct packed {
		logic        valid;
		logic        mark;
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [7:0]  task_id;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] key_sec;
		logic [29:0] key_nsec;
		logic [7:0]  task_id;
		entry_t      head;
	} cmd_t;

	// True when time a is at or after time b; seconds wrap.
	function automatic logic time_ge(input logic [31:0] as, input logic [29:0] an,
			input logic [31:0] bs, input logic [29:0] bn);
		logic [31:0] diff;
		diff = as - bs;
		if (as == bs) begin
			return an >= bn;
		end
		return !diff[31];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dsq_cell.sv -----
// One slot of the sorted queue: holds an entry and moves it to or from its neighbours.
// Depends on dsq_pkg.
`default_nettype none

module dsq_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dsq_pkg::cmd_t cmd,
	input  wire dsq_pkg::entry_t left,
	input  wire dsq_pkg::entry_t right,
	input  wire logic          found_in,
	output logic               found_out,
	output logic               sel,
	output dsq_pkg::entry_t    entry
);

	logic            valid_q;
	logic            mark_q;
	logic [31:0]     sec_q;
	logic [29:0]     nsec_q;
	logic [7:0]      task_q;
	logic            ge;
	logic            hit;
	logic            keep_head;
	dsq_pkg::entry_t nxt;

	assign entry = '{valid: valid_q, mark: mark_q, sec: sec_q, nsec: nsec_q, task_id: task_q};

	always_comb begin
		ge        = dsq_pkg::time_ge(cmd.key_sec, cmd.key_nsec, sec_q, nsec_q);
		keep_head = cmd.head.valid && !cmd.head.mark;
		hit       = 1'b0;
		nxt       = entry;
		unique case (cmd.op)
			dsq_pkg::OP_MARK: begin
				nxt.mark = valid_q && ge;
			end
			dsq_pkg::OP_STEP: begin
				if (valid_q && !right.valid && keep_head) begin
					nxt      = cmd.head;
					nxt.mark = 1'b0;
				end else begin
					nxt = right;
				end
			end
			dsq_pkg::OP_INSERT: begin
				hit = !valid_q || !ge;
				if (found_in) begin
					nxt = left;
				end else if (hit) begin
					nxt = '{valid: 1'b1, mark: 1'b0, sec: cmd.key_sec,
						nsec: cmd.key_nsec, task_id: cmd.task_id};
				end
			end
			dsq_pkg::OP_REMOVE: begin
				hit = valid_q && (task_q == cmd.task_id);
				if (found_in || hit) begin
					nxt = right;
				end
			end
			default: begin
				nxt = entry;
			end
		endcase
		found_out = found_in || hit;
		sel       = hit && !found_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
			mark_q  <= nxt.mark;
		end
	end

	always_ff @(posedge clk) begin
		sec_q  <= nxt.sec;
		nsec_q <= nxt.nsec;
		task_q <= nxt.task_id;
	end

endmodule

`default_nettype wire

// ----- rtl/core/deadline_sleep_queue_core.sv -----
// Deadline sleep queue: a row of dsq_cell slots kept sorted by deadline, with its sequencer.
// Depends on dsq_pkg and dsq_cell.
// A rejected add replies in the cycle after its start, an accepted one after carry and insert.
// A cancel replies after remove, or after remove and reply when found; a tick marks, then rotates
// the entries through the head slot, giving at most one wakeup word per cycle (none when empty).
// Busy stays high until an item is finished; reset clears every slot's valid flag at once.
`default_nettype none

module deadline_sleep_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  task_id,
	input  wire logic [31:0] now_sec,
	input  wire logic [29:0] now_nsec,
	input  wire logic [31:0] dur_sec,
	input  wire logic [29:0] dur_nsec,
	output logic             valid,
	output logic [1:0]       result_kind,
	output logic [7:0]       task_out,
	output logic [1:0]       status,
	output logic             expired,
	output logic [31:0]      rem_sec,
	output logic [29:0]      rem_nsec,
	output logic             last
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_CARRY  = 7'b0000010,
		ST_INSERT = 7'b0000100,
		ST_REMOVE = 7'b0001000,
		ST_REPLY  = 7'b0010000,
		ST_MARK   = 7'b0100000,
		ST_STEP   = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   steps_q;
	logic [7:0]         task_q;
	logic [31:0]        now_sec_q;
	logic [29:0]        now_nsec_q;
	logic [31:0]        dl_sec_q;
	logic [30:0]        dl_nsec_q;
	dsq_pkg::entry_t    match_q;

	logic               valid_q;
	logic [1:0]         kind_q;
	logic [7:0]         task_out_q;
	logic [1:0]         status_q;
	logic               expired_q;
	logic [31:0]        rem_sec_q;
	logic [29:0]        rem_nsec_q;
	logic               last_q;

	dsq_pkg::cmd_t      cmd;
	dsq_pkg::entry_t    cells [QUEUE_DEPTH];
	logic               found [QUEUE_DEPTH+1];
	logic [QUEUE_DEPTH-1:0] sel;
	dsq_pkg::entry_t    empty;
	dsq_pkg::entry_t    matched;
	logic               others_marked;
	logic               reply_exp;
	logic               borrow;
	logic [31:0]        nsec_wide;

	assign empty    = '0;
	assign found[0] = 1'b0;
	assign busy     = (state_q != ST_IDLE);

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		dsq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left     ((i == 0) ? empty : cells[(i == 0) ? 0 : i-1]),
			.right    ((i == QUEUE_DEPTH-1) ? empty : cells[(i == QUEUE_DEPTH-1) ? i : i+1]),
			.found_in (found[i]),
			.found_out(found[i+1]),
			.sel      (sel[i]),
			.entry    (cells[i])
		);
	end

	always_comb begin
		cmd.key_sec  = now_sec_q;
		cmd.key_nsec = now_nsec_q;
		cmd.task_id  = task_q;
		cmd.head     = cells[0];
		unique case (state_q)
			ST_MARK:   cmd.op = dsq_pkg::OP_MARK;
			ST_STEP:   cmd.op = dsq_pkg::OP_STEP;
			ST_REMOVE: cmd.op = dsq_pkg::OP_REMOVE;
			ST_INSERT: begin
				cmd.op       = dsq_pkg::OP_INSERT;
				cmd.key_sec  = dl_sec_q;
				cmd.key_nsec = dl_nsec_q[29:0];
			end
			default:   cmd.op = dsq_pkg::OP_HOLD;
		endcase
	end

	always_comb begin
		others_marked = 1'b0;
		matched       = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (i > 0) begin
				others_marked = others_marked | (cells[i].valid & cells[i].mark);
			end
			matched = matched | (sel[i] ? cells[i] : '0);
		end
	end

	always_comb begin
		reply_exp = dsq_pkg::time_ge(now_sec_q, now_nsec_q, match_q.sec, match_q.nsec);
		borrow    = match_q.nsec < now_nsec_q;
		nsec_wide = {2'b00, match_q.nsec} + (borrow ? {2'b00, dsq_pkg::NSEC_PER_SEC} : 32'd0)
			- {2'b00, now_nsec_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			steps_q <= '0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (dsq_pkg::kind_t'(kind))
							dsq_pkg::KIND_TICK: begin
								if (count_q != '0) begin
									state_q <= ST_MARK;
								end
							end
							dsq_pkg::KIND_ADD: begin
								if (dur_nsec >= dsq_pkg::NSEC_PER_SEC ||
										count_q == CNT_W'(QUEUE_DEPTH)) begin
									valid_q <= 1'b1;
								end else begin
									state_q <= ST_CARRY;
								end
							end
							dsq_pkg::KIND_CANCEL: state_q <= ST_REMOVE;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CARRY: begin
					if (dl_nsec_q < {1'b0, dsq_pkg::NSEC_PER_SEC}) begin
						state_q <= ST_INSERT;
					end
				end
				ST_INSERT: begin
					count_q <= count_q + 1'b1;
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_REMOVE: begin
					if (found[QUEUE_DEPTH]) begin
						count_q <= count_q - 1'b1;
						state_q <= ST_REPLY;
					end else begin
						valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_REPLY: begin
					valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_MARK: begin
					steps_q <= count_q;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (cells[0].valid && cells[0].mark) begin
						valid_q <= 1'b1;
						count_q <= count_q - 1'b1;
					end
					steps_q <= steps_q - 1'b1;
					if (steps_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					task_q     <= task_id;
					now_sec_q  <= now_sec;
					now_nsec_q <= now_nsec;
					dl_sec_q   <= now_sec + dur_sec;
					dl_nsec_q  <= {1'b0, now_nsec} + {1'b0, dur_nsec};
					kind_q     <= kind;
					task_out_q <= task_id;
					expired_q  <= 1'b0;
					rem_sec_q  <= '0;
					rem_nsec_q <= '0;
					last_q     <= 1'b1;
					status_q   <= (dur_nsec >= dsq_pkg::NSEC_PER_SEC) ? dsq_pkg::STATUS_BAD_NSEC :
						dsq_pkg::STATUS_FULL;
				end
			end
			ST_CARRY: begin
				if (dl_nsec_q >= {1'b0, dsq_pkg::NSEC_PER_SEC}) begin
					dl_sec_q  <= dl_sec_q + 32'd1;
					dl_nsec_q <= dl_nsec_q - {1'b0, dsq_pkg::NSEC_PER_SEC};
				end
			end
			ST_INSERT: begin
				status_q <= dsq_pkg::STATUS_OK;
			end
			ST_REMOVE: begin
				match_q   <= matched;
				status_q  <= dsq_pkg::STATUS_NOT_FOUND;
				expired_q <= 1'b1;
			end
			ST_REPLY: begin
				status_q  <= dsq_pkg::STATUS_OK;
				expired_q <= reply_exp;
				if (!reply_exp) begin
					rem_sec_q  <= match_q.sec - now_sec_q - {31'd0, borrow};
					rem_nsec_q <= nsec_wide[29:0];
				end
			end
			ST_STEP: begin
				kind_q     <= dsq_pkg::KIND_TICK;
				task_out_q <= cells[0].task_id;
				status_q   <= dsq_pkg::STATUS_OK;
				expired_q  <= 1'b0;
				rem_sec_q  <= '0;
				rem_nsec_q <= '0;
				last_q     <= !others_marked;
			end
			default: begin
				task_q <= task_q;
			end
		endcase
	end

	assign valid       = valid_q;
	assign result_kind = kind_q;
	assign task_out    = task_out_q;
	assign status      = status_q;
	assign expired     = expired_q;
	assign rem_sec     = rem_sec_q;
	assign rem_nsec    = rem_nsec_q;
	assign last        = last_q;

endmodule

`default_nettype wire
